/* rtl/core/rcc_pkg.sv */
// rcc_pkg: shared types, codes and helpers for the refcounted cache core
// used by rcc_table, rcc_alu, the top level and its checker
`timescale 1ns / 1ps
`default_nettype none

package rcc_pkg;

    // command codes
    localparam logic [2:0] CMD_GET    = 3'd0;
    localparam logic [2:0] CMD_LOOKUP = 3'd1;
    localparam logic [2:0] CMD_REL    = 3'd2;
    localparam logic [2:0] CMD_QUERY  = 3'd3;
    localparam logic [2:0] CMD_DEL    = 3'd4;
    localparam logic [2:0] CMD_POLL   = 3'd5;
    localparam logic [2:0] CMD_DALL   = 3'd6;

    // status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_INSERTED = 3'd1;
    localparam logic [2:0] ST_NOTFOUND = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_LOADFAIL = 3'd4;

    // configuration register indexes
    localparam logic CFG_TIMEOUT  = 1'b0;
    localparam logic CFG_CAPACITY = 1'b1;

    // freed results per poll or delete-all
    localparam int unsigned RESULT_LIMIT = 32;
    localparam int unsigned NRES_W       = $clog2(RESULT_LIMIT + 1);

    typedef struct packed {
        logic [31:0]        id;
        logic [31:0]        handle;
        logic signed [15:0] refs;
        logic [31:0]        stamp;
    } t_entry;

    typedef struct packed {
        logic [2:0]         status;
        logic [31:0]        handle;
        logic signed [15:0] refs;
        logic               freed;
        logic               last;
    } t_result;

    typedef struct packed {
        logic               id_eq;
        logic signed [15:0] ref_inc;
        logic signed [15:0] ref_dec;
        logic               evict;
    } t_alu_out;

    function automatic t_result make_res(input logic [2:0] status,
                                         input logic [31:0] handle,
                                         input logic signed [15:0] refs,
                                         input logic freed,
                                         input logic last);
        t_result r;
        r.status = status;
        r.handle = handle;
        r.refs   = refs;
        r.freed  = freed;
        r.last   = last;
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/rcc_table.sv */
// rcc_table: entry storage, one write port and one registered read port
// depends on rcc_pkg for the entry type
`timescale 1ns / 1ps
`default_nettype none

module rcc_table #(
    parameter int unsigned CAPACITY = 32,
    parameter int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
    input  wire logic            i_clk,
    input  wire logic [AW-1:0]   i_rd_addr,
    output rcc_pkg::t_entry      o_rd_data,
    input  wire logic            i_wr_en,
    input  wire logic [AW-1:0]   i_wr_addr,
    input  wire rcc_pkg::t_entry i_wr_data
);
    import rcc_pkg::*;

    t_entry r_mem [CAPACITY];
    t_entry r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

/* rtl/core/rcc_alu.sv */
// rcc_alu: shared compare and count unit applied to the entry just read
// depends on rcc_pkg for entry and result types
`timescale 1ns / 1ps
`default_nettype none

module rcc_alu (
    input  wire rcc_pkg::t_entry i_ent,
    input  wire logic [31:0]     i_id,
    input  wire logic [31:0]     i_now,
    input  wire logic [31:0]     i_timeout,
    output rcc_pkg::t_alu_out    o_res
);
    import rcc_pkg::*;

    logic [31:0] idle;

    // idle time, wrapping
    assign idle = i_now - i_ent.stamp;

    always_comb begin
        o_res.id_eq   = (i_ent.id == i_id);
        o_res.ref_inc = (i_ent.refs == 16'sh7fff) ? i_ent.refs : i_ent.refs + 16'sd1;
        o_res.ref_dec = (i_ent.refs == -16'sh8000) ? i_ent.refs : i_ent.refs - 16'sd1;
        o_res.evict   = (i_ent.id != 32'd0) && (i_ent.refs <= 16'sd0)
                        && (idle > i_timeout);
    end

endmodule

`default_nettype wire

/* rtl/core/refcount_cache_with_idle_eviction_core.sv */
// refcount_cache_with_idle_eviction_core: sequencer, table and shared unit
// depends on rcc_pkg, rcc_table and rcc_alu
`timescale 1ns / 1ps
`default_nettype none

// Command-style cache of reference-counted resources.
// A command is taken at a clock edge with i_start high and o_busy low; the
// fields are sampled there. Results appear on the o_ ports for one cycle
// with o_valid high; o_last marks the final result of the command. The
// receiver cannot stall, so each result is a transfer in its own cycle.
// Rate: the id search reads one entry per cycle from the single read port
// of the table for get/lookup/release/query/delete. A delete then shifts
// the later entries down, one entry a cycle over the same port. A poll
// scans from the back, one entry a cycle, with a shift after each eviction;
// delete-all frees entry 0 and shifts the rest down in each round. A poll
// with a zero timeout, an empty poll or delete-all, and an unused command
// answer in the cycle after the start and leave o_busy low.
// Configuration writes (i_cfg_we, i_cfg_idx, i_cfg_data) take effect at
// once; the user must make them while the block is idle; nothing guards it.
// Reset (i_rst_n low, synchronous) empties the table and clears both
// configuration registers; entry contents are not cleared.
module refcount_cache_with_idle_eviction_core #(
    parameter int unsigned CAPACITY = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    output logic                    o_busy,
    input  wire logic [2:0]         i_command,
    input  wire logic [31:0]        i_res_id,
    input  wire logic [31:0]        i_now_ms,
    input  wire logic               i_load_ok,
    input  wire logic [31:0]        i_load_handle,
    output logic                    o_valid,
    output logic [2:0]              o_status,
    output logic [31:0]             o_handle,
    output logic signed [15:0]      o_ref_count,
    output logic                    o_freed,
    output logic                    o_last,
    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_idx,
    input  wire logic [31:0]        i_cfg_data
);
    import rcc_pkg::*;

    localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam logic [6:0] CAP_MAX = 7'(CAPACITY);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FIND  = 3'd1;
    localparam logic [2:0] S_SHIFT = 3'd2;
    localparam logic [2:0] S_PSCAN = 3'd3;
    localparam logic [2:0] S_PNEXT = 3'd4;
    localparam logic [2:0] S_DALL  = 3'd5;
    localparam logic [2:0] S_DNEXT = 3'd6;
    localparam logic [2:0] S_FIN   = 3'd7;

    logic [2:0]         r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_ptr, n_ptr;
    logic [AW-1:0]      r_scan, n_scan;
    logic [NRES_W-1:0]  r_nres, n_nres;
    logic [2:0]         r_cmd, n_cmd;
    logic [31:0]        r_id, n_id;
    logic [31:0]        r_now, n_now;
    logic               r_ok, n_ok;
    logic [31:0]        r_lh, n_lh;
    logic               r_pend_v, n_pend_v;
    logic [31:0]        r_pend_handle, n_pend_handle;
    logic signed [15:0] r_pend_ref, n_pend_ref;
    logic               r_out_v, n_out_v;
    t_result            r_out, n_out;
    logic [31:0]        r_timeout;
    logic [5:0]         r_cap;

    logic [AW-1:0]      rd_addr;
    t_entry             rd_data;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    t_entry             wr_data;
    t_alu_out           alu;
    logic [6:0]         cap_eff;
    logic [CW:0]        ptr_p1;
    logic [CW:0]        ptr_p2;
    logic               scan_done;

    rcc_table #(.CAPACITY(CAPACITY), .AW(AW)) u_table (
        .i_clk     (i_clk),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    rcc_alu u_alu (
        .i_ent     (rd_data),
        .i_id      (r_id),
        .i_now     (r_now),
        .i_timeout (r_timeout),
        .o_res     (alu)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= '0;
            r_cap     <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TIMEOUT:  r_timeout <= i_cfg_data;
                CFG_CAPACITY: r_cap     <= i_cfg_data[5:0];
                default:      r_timeout <= r_timeout;
            endcase
        end
    end

    assign cap_eff   = ({1'b0, r_cap} > CAP_MAX) ? CAP_MAX : {1'b0, r_cap};
    assign ptr_p1    = {1'b0, r_ptr} + (CW + 1)'(1);
    assign ptr_p2    = {1'b0, r_ptr} + (CW + 1)'(2);
    assign scan_done = (r_scan == '0) || (r_nres == NRES_W'(RESULT_LIMIT));

    // sequencer
    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_ptr         = r_ptr;
        n_scan        = r_scan;
        n_nres        = r_nres;
        n_cmd         = r_cmd;
        n_id          = r_id;
        n_now         = r_now;
        n_ok          = r_ok;
        n_lh          = r_lh;
        n_pend_v      = r_pend_v;
        n_pend_handle = r_pend_handle;
        n_pend_ref    = r_pend_ref;
        n_out_v       = 1'b0;
        n_out         = r_out;
        rd_addr       = '0;
        wr_en         = 1'b0;
        wr_addr       = r_ptr[AW-1:0];
        wr_data       = rd_data;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_cmd = i_command;
                    n_id  = i_res_id;
                    n_now = i_now_ms;
                    n_ok  = i_load_ok;
                    n_lh  = i_load_handle;
                    n_nres   = '0;
                    n_pend_v = 1'b0;
                    case (i_command)
                        CMD_GET, CMD_LOOKUP, CMD_REL, CMD_QUERY, CMD_DEL: begin
                            n_ptr   = '0;
                            n_state = S_FIND;
                        end
                        CMD_POLL: begin
                            if (r_timeout == 32'd0 || r_count == '0) begin
                                n_out_v = 1'b1;
                                n_out   = make_res(ST_OK, 32'd0, 16'sd0, 1'b0, 1'b1);
                            end else begin
                                rd_addr = AW'(r_count - CW'(1));
                                n_scan  = AW'(r_count - CW'(1));
                                n_state = S_PSCAN;
                            end
                        end
                        CMD_DALL: begin
                            if (r_count == '0) begin
                                n_out_v = 1'b1;
                                n_out   = make_res(ST_OK, 32'd0, 16'sd0, 1'b0, 1'b1);
                            end else begin
                                n_state = S_DALL;
                            end
                        end
                        default: begin
                            n_out_v = 1'b1;
                            n_out   = make_res(ST_NOTFOUND, 32'd0, 16'sd0, 1'b0, 1'b1);
                        end
                    endcase
                end
            end

            // id search, one entry a cycle
            S_FIND: begin
                if (r_ptr >= r_count) begin
                    n_out_v = 1'b1;
                    n_state = S_IDLE;
                    if (r_cmd == CMD_GET) begin
                        if ({{(7 - CW){1'b0}}, r_count} >= cap_eff) begin
                            n_out = make_res(ST_FULL, 32'd0, 16'sd0, 1'b0, 1'b1);
                        end else if (!r_ok) begin
                            n_out = make_res(ST_LOADFAIL, 32'd0, 16'sd0, 1'b0, 1'b1);
                        end else begin
                            wr_en          = 1'b1;
                            wr_addr        = r_count[AW-1:0];
                            wr_data.id     = r_id;
                            wr_data.handle = r_lh;
                            wr_data.refs   = 16'sd1;
                            wr_data.stamp  = 32'd0;
                            n_count        = r_count + CW'(1);
                            n_out = make_res(ST_INSERTED, r_lh, 16'sd1, 1'b0, 1'b1);
                        end
                    end else begin
                        n_out = make_res(ST_NOTFOUND, 32'd0, 16'sd0, 1'b0, 1'b1);
                    end
                end else if (alu.id_eq) begin
                    n_out_v = 1'b1;
                    n_state = S_IDLE;
                    case (r_cmd)
                        CMD_GET, CMD_LOOKUP: begin
                            wr_en        = 1'b1;
                            wr_data.refs = alu.ref_inc;
                            n_out = make_res(ST_OK, rd_data.handle, alu.ref_inc, 1'b0, 1'b1);
                        end
                        CMD_REL: begin
                            wr_en         = 1'b1;
                            wr_data.refs  = alu.ref_dec;
                            wr_data.stamp = r_now;
                            n_out = make_res(ST_OK, 32'd0, alu.ref_dec, 1'b0, 1'b1);
                        end
                        CMD_QUERY: begin
                            n_out = make_res(ST_OK, 32'd0, rd_data.refs, 1'b0, 1'b1);
                        end
                        default: begin
                            if (r_id == 32'd0) begin
                                n_out = make_res(ST_NOTFOUND, 32'd0, 16'sd0, 1'b0, 1'b1);
                            end else begin
                                n_out = make_res(ST_OK, rd_data.handle, rd_data.refs,
                                                 1'b1, 1'b1);
                                rd_addr = ptr_p1[AW-1:0];
                                n_state = S_SHIFT;
                            end
                        end
                    endcase
                end else begin
                    n_ptr   = ptr_p1[CW-1:0];
                    rd_addr = ptr_p1[AW-1:0];
                end
            end

            // close the gap at r_ptr, one entry a cycle
            S_SHIFT: begin
                if (ptr_p1 < {1'b0, r_count}) begin
                    wr_en   = 1'b1;
                    n_ptr   = ptr_p1[CW-1:0];
                    rd_addr = ptr_p2[AW-1:0];
                end else begin
                    n_count = r_count - CW'(1);
                    case (r_cmd)
                        CMD_POLL: n_state = S_PNEXT;
                        CMD_DALL: n_state = S_DNEXT;
                        default:  n_state = S_IDLE;
                    endcase
                end
            end

            // poll scan from the back
            S_PSCAN: begin
                if (alu.evict) begin
                    if (r_pend_v) begin
                        n_out_v = 1'b1;
                        n_out   = make_res(ST_OK, r_pend_handle, r_pend_ref, 1'b1, 1'b0);
                    end
                    n_pend_v      = 1'b1;
                    n_pend_handle = rd_data.handle;
                    n_pend_ref    = rd_data.refs;
                    n_nres        = r_nres + NRES_W'(1);
                    n_ptr         = CW'(r_scan);
                    rd_addr       = AW'({1'b0, r_scan} + (AW + 1)'(1));
                    n_state       = S_SHIFT;
                end else if (scan_done) begin
                    n_state = S_FIN;
                end else begin
                    rd_addr = r_scan - AW'(1);
                    n_scan  = r_scan - AW'(1);
                end
            end

            S_PNEXT: begin
                if (scan_done) begin
                    n_state = S_FIN;
                end else begin
                    rd_addr = r_scan - AW'(1);
                    n_scan  = r_scan - AW'(1);
                    n_state = S_PSCAN;
                end
            end

            // delete-all frees the front entry each round
            S_DALL: begin
                if (r_pend_v) begin
                    n_out_v = 1'b1;
                    n_out   = make_res(ST_OK, r_pend_handle, r_pend_ref, 1'b1, 1'b0);
                end
                n_pend_v      = 1'b1;
                n_pend_handle = rd_data.handle;
                n_pend_ref    = rd_data.refs;
                n_nres        = r_nres + NRES_W'(1);
                n_ptr         = '0;
                rd_addr       = AW'(1);
                n_state       = S_SHIFT;
            end

            S_DNEXT: begin
                if (r_count == '0 || r_nres == NRES_W'(RESULT_LIMIT)) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_DALL;
                end
            end

            // final result of poll or delete-all
            S_FIN: begin
                n_out_v  = 1'b1;
                n_pend_v = 1'b0;
                n_state  = S_IDLE;
                if (r_pend_v) begin
                    n_out = make_res(ST_OK, r_pend_handle, r_pend_ref, 1'b1, 1'b1);
                end else begin
                    n_out = make_res(ST_OK, 32'd0, 16'sd0, 1'b0, 1'b1);
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_out_v  <= 1'b0;
            r_pend_v <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_out_v  <= n_out_v;
            r_pend_v <= n_pend_v;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_ptr         <= n_ptr;
        r_scan        <= n_scan;
        r_nres        <= n_nres;
        r_cmd         <= n_cmd;
        r_id          <= n_id;
        r_now         <= n_now;
        r_ok          <= n_ok;
        r_lh          <= n_lh;
        r_pend_handle <= n_pend_handle;
        r_pend_ref    <= n_pend_ref;
        r_out         <= n_out;
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_valid     = r_out_v;
    assign o_status    = r_out.status;
    assign o_handle    = r_out.handle;
    assign o_ref_count = r_out.refs;
    assign o_freed     = r_out.freed;
    assign o_last      = r_out.last;

endmodule

`default_nettype wire

/* rtl/core/rcc_checker.sv */
// rcc_checker: port-level checks on the refcounted cache core
// depends on rcc_pkg; bound to refcount_cache_with_idle_eviction_core
`timescale 1ns / 1ps
`default_nettype none

module rcc_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_start,
    input wire logic               o_busy,
    input wire logic [2:0]         i_command,
    input wire logic               o_valid,
    input wire logic [2:0]         o_status,
    input wire logic [31:0]        o_handle,
    input wire logic signed [15:0] o_ref_count,
    input wire logic               o_freed,
    input wire logic               o_last
);
    import rcc_pkg::*;

    // a freed handle is always reported as ok
    a_freed_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_freed |-> o_status == ST_OK)
        else $error("freed result with non-ok status");

    // failures are single results with empty fields
    a_fail_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK && o_status != ST_INSERTED
        |-> o_last && o_handle == 32'd0 && o_ref_count == 16'sd0 && !o_freed)
        else $error("failure result not final or not empty");

    // unused command answers not found in the next cycle
    a_unused_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !o_busy && i_command == 3'd7
        |=> o_valid && o_last && o_status == ST_NOTFOUND)
        else $error("unused command not answered");

    // more results pending keeps the block busy
    a_more_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> o_busy)
        else $error("non-final result while idle");

    // reset leaves nothing on the result ports
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_busy)
        else $error("activity after reset");

endmodule

bind refcount_cache_with_idle_eviction_core rcc_checker u_rcc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_start     (i_start),
    .o_busy      (o_busy),
    .i_command   (i_command),
    .o_valid     (o_valid),
    .o_status    (o_status),
    .o_handle    (o_handle),
    .o_ref_count (o_ref_count),
    .o_freed     (o_freed),
    .o_last      (o_last)
);

`default_nettype wire
